[rtl/core/nrm_pkg.sv]
// Shared types, register indexes and stage helpers for the NDHWC/NCDHW to
// NDC1HWC0 index remapper. No dependencies.
`default_nettype none

package nrm_pkg;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_BATCH   = 3'd0;
   localparam reg_index_type REG_DEPTH   = 3'd1;
   localparam reg_index_type REG_HEIGHT  = 3'd2;
   localparam reg_index_type REG_WIDTH   = 3'd3;
   localparam reg_index_type REG_CHANNEL = 3'd4;
   localparam reg_index_type REG_BLOCK   = 3'd5;
   localparam reg_index_type REG_FORMAT  = 3'd6;

   localparam int unsigned CFG_BITS   = 13;
   localparam int unsigned POS_BITS   = 12;
   localparam int unsigned OFF_BITS   = 5;
   localparam int unsigned C0_BITS    = 6;
   localparam int unsigned DIV_STEPS  = 12;
   localparam int unsigned MAC_STAGES = 5;
   localparam int unsigned DEST_BITS  = 32;

   localparam logic [CFG_BITS-1:0] COUNT_MAX = 13'd4096;
   localparam logic [C0_BITS-1:0]  BLOCK_MAX = 6'd32;

   // Effective (clamped) tensor shape seen by the counters and the index pipe.
   typedef struct packed {
      logic [CFG_BITS-1:0] nn;
      logic [CFG_BITS-1:0] dd;
      logic [CFG_BITS-1:0] hh;
      logic [CFG_BITS-1:0] ww;
      logic [CFG_BITS-1:0] cc;
      logic [CFG_BITS-1:0] c1;
      logic [C0_BITS-1:0]  c0;
      logic                ncdhw;
   } dims_type;

   // Coordinates and shape captured with each request for the index pipe.
   typedef struct packed {
      logic                last;
      logic [POS_BITS-1:0] dpos;
      logic [POS_BITS-1:0] cbp;
      logic [POS_BITS-1:0] hpos;
      logic [POS_BITS-1:0] wpos;
      logic [OFF_BITS-1:0] off;
      logic [CFG_BITS-1:0] dd;
      logic [CFG_BITS-1:0] c1;
      logic [CFG_BITS-1:0] hh;
      logic [CFG_BITS-1:0] ww;
      logic [C0_BITS-1:0]  c0;
   } snap_type;

   // Multiplier operand of each multiply-add stage.
   function automatic logic [CFG_BITS-1:0] stage_dim(input snap_type s, input int unsigned k);
      logic [CFG_BITS-1:0] d;
      case (k)
         0:       d = s.dd;
         1:       d = s.c1;
         2:       d = s.hh;
         3:       d = s.ww;
         4:       d = CFG_BITS'(s.c0);
         default: d = '0;
      endcase
      return d;
   endfunction

   // Addend of each multiply-add stage.
   function automatic logic [POS_BITS-1:0] stage_add(input snap_type s, input int unsigned k);
      logic [POS_BITS-1:0] a;
      case (k)
         0:       a = s.dpos;
         1:       a = s.cbp;
         2:       a = s.hpos;
         3:       a = s.wpos;
         4:       a = POS_BITS'(s.off);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ndhwc_to_ndc1hwc0_remap.sv]
// Top level of the NDHWC/NCDHW to NDC1HWC0 destination index generator.
// Depends on nrm_pkg, nrm_cfg, nrm_coord and nrm_mac.
//
// Usage:
//   Elements enter on the req_ stream in source memory order (NDHWC, or NCDHW
//   when the format register is set). Each request leaves on the rsp_ stream
//   with its NDC1HWC0 destination index, the element itself, tlast on the
//   final element of the tensor and tuser set when the index did not fit.
//   Shape and format registers are written through the csr_ port; the user
//   must write them only while the stream is idle; the block does not enforce this.
//   The index is built by a chain of five registered multiply-add stages, one
//   per destination dimension below the batch. Throughput is one element per
//   cycle while the receiver takes responses and the divider is idle; the
//   coordinate counters step once per accepted request.
//   After a write to channel_count or block_width, req_tready stays low
//   while a bit-serial divider recomputes the channel block count.
//   Reset clears the counters and empties the pipe; the shape registers
//   return to a 1x1x1x1x1 tensor with a block width of 16.
//   When the receiver stalls, the stages fill up and req_tready falls only
//   once every stage holds a response.
`default_nettype none

module ndhwc_to_ndc1hwc0_remap #(
   parameter int unsigned ELEMENT_BITS = 16,
   parameter int unsigned INDEX_BITS   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: element_value
   input  wire logic [((ELEMENT_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: dest_index, element_out
   output logic [((nrm_pkg::DEST_BITS+ELEMENT_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_tlast,
   // rsp_tuser: index_overflow
   output logic                                   rsp_tuser,
   input  wire logic                              csr_we,
   input  wire nrm_pkg::reg_index_type            csr_index,
   input  wire logic [nrm_pkg::CFG_BITS-1:0]      csr_wdata
);

   localparam int unsigned RSP_BITS  = ((nrm_pkg::DEST_BITS + ELEMENT_BITS + 7) / 8) * 8;
   localparam int unsigned SNAP_BITS = $bits(nrm_pkg::snap_type);
   localparam int unsigned PAY_BITS  = ELEMENT_BITS + SNAP_BITS;
   localparam int unsigned STAGES    = nrm_pkg::MAC_STAGES;

   nrm_pkg::dims_type            dims;
   nrm_pkg::snap_type            snap_src;
   nrm_pkg::snap_type            snap_out;
   logic                         cfg_busy;
   logic                         accept;
   logic [nrm_pkg::POS_BITS-1:0] batch_pos;

   logic                  valid [0:STAGES];
   logic                  ready [0:STAGES];
   logic [INDEX_BITS-1:0] acc   [0:STAGES];
   logic                  ov    [0:STAGES];
   logic [PAY_BITS-1:0]   pay   [0:STAGES];

   logic [nrm_pkg::DEST_BITS-1:0] dest_index;
   logic [ELEMENT_BITS-1:0]       element_out;

   nrm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dims      (dims),
      .busy      (cfg_busy)
   );

   assign req_tready = ready[0] && !cfg_busy;
   assign accept     = req_tvalid && req_tready;

   nrm_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .dims      (dims),
      .batch_pos (batch_pos),
      .snap      (snap_src)
   );

   assign valid[0] = req_tvalid && !cfg_busy;
   assign acc[0]   = INDEX_BITS'(batch_pos);
   assign ov[0]    = 1'b0;
   assign pay[0]   = {req_tdata[ELEMENT_BITS-1:0], snap_src};

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      nrm_pkg::snap_type snap_k;

      assign snap_k = nrm_pkg::snap_type'(pay[k][SNAP_BITS-1:0]);

      nrm_mac #(
         .ACC_BITS (INDEX_BITS),
         .PAY_BITS (PAY_BITS)
      ) u_mac (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[k]),
         .in_ready  (ready[k]),
         .in_acc    (acc[k]),
         .in_ov     (ov[k]),
         .in_dim    (nrm_pkg::stage_dim(snap_k, k)),
         .in_add    (nrm_pkg::stage_add(snap_k, k)),
         .in_pay    (pay[k]),
         .out_valid (valid[k+1]),
         .out_ready (ready[k+1]),
         .out_acc   (acc[k+1]),
         .out_ov    (ov[k+1]),
         .out_pay   (pay[k+1])
      );
   end

   assign ready[STAGES] = rsp_tready;

   if (INDEX_BITS >= nrm_pkg::DEST_BITS) begin : g_dest_trunc
      assign dest_index = acc[STAGES][nrm_pkg::DEST_BITS-1:0];
   end else begin : g_dest_ext
      assign dest_index = nrm_pkg::DEST_BITS'(acc[STAGES]);
   end

   assign snap_out    = nrm_pkg::snap_type'(pay[STAGES][SNAP_BITS-1:0]);
   assign element_out = pay[STAGES][SNAP_BITS +: ELEMENT_BITS];

   assign rsp_tvalid = valid[STAGES];
   assign rsp_tdata  = RSP_BITS'({element_out, dest_index});
   assign rsp_tlast  = snap_out.last;
   assign rsp_tuser  = ov[STAGES];

endmodule

`default_nettype wire

[rtl/core/nrm_div.sv]
// Bit-serial restoring divider that derives the channel block count
// C1 = (C-1)/C0 + 1. Depends on nrm_pkg.
`default_nettype none

module nrm_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [nrm_pkg::POS_BITS-1:0] dividend,
   input  wire logic [nrm_pkg::C0_BITS-1:0]  divisor,
   output logic                              busy,
   output logic [nrm_pkg::CFG_BITS-1:0]      c1
);

   logic                         busy_ff, busy_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic [nrm_pkg::C0_BITS-1:0]  rem_ff, rem_in;
   logic [nrm_pkg::POS_BITS-1:0] quo_ff, quo_in;
   logic [nrm_pkg::CFG_BITS-1:0] c1_ff, c1_in;
   logic [nrm_pkg::C0_BITS:0]    trial;
   logic                         fits;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      c1_in   = c1_ff;
      trial   = {rem_ff, quo_ff[nrm_pkg::POS_BITS-1]};
      fits    = trial >= {1'b0, divisor};
      if (busy_ff) begin
         rem_in = fits ? nrm_pkg::C0_BITS'(trial - {1'b0, divisor})
                       : trial[nrm_pkg::C0_BITS-1:0];
         quo_in = {quo_ff[nrm_pkg::POS_BITS-2:0], fits};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            c1_in   = nrm_pkg::CFG_BITS'(quo_in) + nrm_pkg::CFG_BITS'(1);
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'(nrm_pkg::DIV_STEPS);
         rem_in  = '0;
         quo_in  = dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         c1_ff   <= nrm_pkg::CFG_BITS'(1);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         c1_ff   <= c1_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign c1   = c1_ff;

endmodule

`default_nettype wire

[rtl/core/nrm_cfg.sv]
// Configuration registers with clamping, plus the block count divider.
// Depends on nrm_pkg and nrm_div.
`default_nettype none

module nrm_cfg (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire nrm_pkg::reg_index_type       csr_index,
   input  wire logic [nrm_pkg::CFG_BITS-1:0] csr_wdata,
   output nrm_pkg::dims_type                 dims,
   output logic                              busy
);

   logic [nrm_pkg::CFG_BITS-1:0] batch_ff, depth_ff, height_ff, width_ff, channel_ff;
   logic [nrm_pkg::C0_BITS-1:0]  block_ff;
   logic                         format_ff;
   logic                         dirty_ff, dirty_in;
   logic                         div_busy;
   logic                         div_start;
   logic [nrm_pkg::CFG_BITS-1:0] c1;

   function automatic logic [nrm_pkg::CFG_BITS-1:0] clamp_count(
      input logic [nrm_pkg::CFG_BITS-1:0] v);
      logic [nrm_pkg::CFG_BITS-1:0] r;
      if (v == '0) begin
         r = nrm_pkg::CFG_BITS'(1);
      end else if (v > nrm_pkg::COUNT_MAX) begin
         r = nrm_pkg::COUNT_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff   <= nrm_pkg::CFG_BITS'(1);
         depth_ff   <= nrm_pkg::CFG_BITS'(1);
         height_ff  <= nrm_pkg::CFG_BITS'(1);
         width_ff   <= nrm_pkg::CFG_BITS'(1);
         channel_ff <= nrm_pkg::CFG_BITS'(1);
         block_ff   <= nrm_pkg::C0_BITS'(16);
         format_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            nrm_pkg::REG_BATCH:   batch_ff   <= csr_wdata;
            nrm_pkg::REG_DEPTH:   depth_ff   <= csr_wdata;
            nrm_pkg::REG_HEIGHT:  height_ff  <= csr_wdata;
            nrm_pkg::REG_WIDTH:   width_ff   <= csr_wdata;
            nrm_pkg::REG_CHANNEL: channel_ff <= csr_wdata;
            nrm_pkg::REG_BLOCK:   block_ff   <= csr_wdata[nrm_pkg::C0_BITS-1:0];
            nrm_pkg::REG_FORMAT:  format_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A write to C or C0 marks the block count stale until the divider reruns.
   always_comb begin
      dirty_in = dirty_ff;
      if (div_start) begin
         dirty_in = 1'b0;
      end
      if (csr_we && (csr_index == nrm_pkg::REG_CHANNEL || csr_index == nrm_pkg::REG_BLOCK)) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
      end
   end

   assign div_start = dirty_ff && !div_busy;

   always_comb begin
      dims.nn    = clamp_count(batch_ff);
      dims.dd    = clamp_count(depth_ff);
      dims.hh    = clamp_count(height_ff);
      dims.ww    = clamp_count(width_ff);
      dims.cc    = clamp_count(channel_ff);
      dims.c1    = c1;
      dims.ncdhw = format_ff;
      if (block_ff == '0) begin
         dims.c0 = nrm_pkg::C0_BITS'(1);
      end else if (block_ff > nrm_pkg::BLOCK_MAX) begin
         dims.c0 = nrm_pkg::BLOCK_MAX;
      end else begin
         dims.c0 = block_ff;
      end
   end

   nrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (nrm_pkg::POS_BITS'(dims.cc - nrm_pkg::CFG_BITS'(1))),
      .divisor  (dims.c0),
      .busy     (div_busy),
      .c1       (c1)
   );

   assign busy = dirty_ff || div_busy;

endmodule

`default_nettype wire

[rtl/core/nrm_coord.sv]
// Source-order coordinate counters that advance once per accepted request.
// Depends on nrm_pkg.
`default_nettype none

module nrm_coord (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire nrm_pkg::dims_type            dims,
   output logic [nrm_pkg::POS_BITS-1:0]      batch_pos,
   output nrm_pkg::snap_type                 snap
);

   localparam int unsigned CH_BITS = 18;

   logic [nrm_pkg::POS_BITS-1:0] batch_pos_ff, batch_pos_in;
   logic [nrm_pkg::POS_BITS-1:0] depth_pos_ff, depth_pos_in;
   logic [nrm_pkg::POS_BITS-1:0] height_pos_ff, height_pos_in;
   logic [nrm_pkg::POS_BITS-1:0] width_pos_ff, width_pos_in;
   logic [nrm_pkg::POS_BITS-1:0] cblk_pos_ff, cblk_pos_in;
   logic [nrm_pkg::OFF_BITS-1:0] coff_pos_ff, coff_pos_in;

   logic [CH_BITS-1:0] ch;
   logic b_end, d_end, h_end, w_end, ch_end, off_end;

   function automatic logic [nrm_pkg::POS_BITS-1:0] step_pos(
      input logic [nrm_pkg::POS_BITS-1:0] p, input logic at_end);
      return at_end ? '0 : p + nrm_pkg::POS_BITS'(1);
   endfunction

   function automatic logic at_last(input logic [nrm_pkg::POS_BITS-1:0] p,
                                    input logic [nrm_pkg::CFG_BITS-1:0] n);
      return (nrm_pkg::CFG_BITS'(p) + nrm_pkg::CFG_BITS'(1)) >= n;
   endfunction

   always_comb begin
      ch      = CH_BITS'(cblk_pos_ff) * CH_BITS'(dims.c0) + CH_BITS'(coff_pos_ff);
      ch_end  = (ch + CH_BITS'(1)) >= CH_BITS'(dims.cc);
      off_end = (nrm_pkg::C0_BITS'(coff_pos_ff) + nrm_pkg::C0_BITS'(1)) >= dims.c0;
      b_end   = at_last(batch_pos_ff, dims.nn);
      d_end   = at_last(depth_pos_ff, dims.dd);
      h_end   = at_last(height_pos_ff, dims.hh);
      w_end   = at_last(width_pos_ff, dims.ww);
   end

   always_comb begin
      batch_pos_in  = batch_pos_ff;
      depth_pos_in  = depth_pos_ff;
      height_pos_in = height_pos_ff;
      width_pos_in  = width_pos_ff;
      cblk_pos_in   = cblk_pos_ff;
      coff_pos_in   = coff_pos_ff;
      if (advance) begin
         // The innermost source dimension always steps; each outer one steps
         // only when every dimension inside it wraps.
         if (dims.ncdhw) begin
            width_pos_in = step_pos(width_pos_ff, w_end);
            if (w_end) begin
               height_pos_in = step_pos(height_pos_ff, h_end);
               if (h_end) begin
                  depth_pos_in = step_pos(depth_pos_ff, d_end);
                  if (d_end) begin
                     if (ch_end) begin
                        cblk_pos_in  = '0;
                        coff_pos_in  = '0;
                        batch_pos_in = step_pos(batch_pos_ff, b_end);
                     end else if (off_end) begin
                        coff_pos_in = '0;
                        cblk_pos_in = cblk_pos_ff + nrm_pkg::POS_BITS'(1);
                     end else begin
                        coff_pos_in = coff_pos_ff + nrm_pkg::OFF_BITS'(1);
                     end
                  end
               end
            end
         end else begin
            if (ch_end) begin
               cblk_pos_in  = '0;
               coff_pos_in  = '0;
               width_pos_in = step_pos(width_pos_ff, w_end);
               if (w_end) begin
                  height_pos_in = step_pos(height_pos_ff, h_end);
                  if (h_end) begin
                     depth_pos_in = step_pos(depth_pos_ff, d_end);
                     if (d_end) begin
                        batch_pos_in = step_pos(batch_pos_ff, b_end);
                     end
                  end
               end
            end else if (off_end) begin
               coff_pos_in = '0;
               cblk_pos_in = cblk_pos_ff + nrm_pkg::POS_BITS'(1);
            end else begin
               coff_pos_in = coff_pos_ff + nrm_pkg::OFF_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_pos_ff  <= '0;
         depth_pos_ff  <= '0;
         height_pos_ff <= '0;
         width_pos_ff  <= '0;
         cblk_pos_ff   <= '0;
         coff_pos_ff   <= '0;
      end else begin
         batch_pos_ff  <= batch_pos_in;
         depth_pos_ff  <= depth_pos_in;
         height_pos_ff <= height_pos_in;
         width_pos_ff  <= width_pos_in;
         cblk_pos_ff   <= cblk_pos_in;
         coff_pos_ff   <= coff_pos_in;
      end
   end

   assign batch_pos = batch_pos_ff;

   always_comb begin
      snap.last = b_end && d_end && h_end && w_end && ch_end;
      snap.dpos = depth_pos_ff;
      snap.cbp  = cblk_pos_ff;
      snap.hpos = height_pos_ff;
      snap.wpos = width_pos_ff;
      snap.off  = coff_pos_ff;
      snap.dd   = dims.dd;
      snap.c1   = dims.c1;
      snap.hh   = dims.hh;
      snap.ww   = dims.ww;
      snap.c0   = dims.c0;
   end

endmodule

`default_nettype wire

[rtl/core/nrm_mac.sv]
// One registered multiply-add stage of the index pipe, acc*dim + add, with
// overflow tracking and a pass-through payload. Depends on nrm_pkg.
`default_nettype none

module nrm_mac #(
   parameter int unsigned ACC_BITS = 32,
   parameter int unsigned PAY_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [ACC_BITS-1:0]          in_acc,
   input  wire logic                         in_ov,
   input  wire logic [nrm_pkg::CFG_BITS-1:0] in_dim,
   input  wire logic [nrm_pkg::POS_BITS-1:0] in_add,
   input  wire logic [PAY_BITS-1:0]          in_pay,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [ACC_BITS-1:0]               out_acc,
   output logic                              out_ov,
   output logic [PAY_BITS-1:0]               out_pay
);

   localparam int unsigned PROD_BITS = ACC_BITS + nrm_pkg::CFG_BITS;
   localparam int unsigned SUM_BITS  = PROD_BITS + 1;

   logic                  valid_ff;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                  ov_ff, ov_in;
   logic [PAY_BITS-1:0]   pay_ff;
   logic [PROD_BITS-1:0]  prod;
   logic [SUM_BITS-1:0]   sum;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Bits above the index width mean the exact index no longer fits; once
   // flagged, the low bits keep wrapping.
   always_comb begin
      prod   = PROD_BITS'(in_acc) * PROD_BITS'(in_dim);
      sum    = SUM_BITS'(prod) + SUM_BITS'(in_add);
      acc_in = sum[ACC_BITS-1:0];
      ov_in  = in_ov || (|sum[SUM_BITS-1:ACC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         acc_ff <= acc_in;
         ov_ff  <= ov_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_ov    = ov_ff;
   assign out_pay   = pay_ff;

endmodule

`default_nettype wire

[rtl/core/nrm_chk.sv]
// Port-level checker for the index remapper, bound to the top level.
// Depends on nrm_pkg and ndhwc_to_ndc1hwc0_remap.
`default_nettype none

module nrm_chk #(
   parameter int unsigned ELEMENT_BITS = 16
) (
   input wire logic                                           clock,
   input wire logic                                           reset,
   input wire logic                                           req_tready,
   input wire logic [((nrm_pkg::DEST_BITS+ELEMENT_BITS+7)/8)*8-1:0] rsp_tdata,
   input wire logic                                           rsp_tvalid,
   input wire logic                                           rsp_tready,
   input wire logic                                           rsp_tlast,
   input wire logic                                           rsp_tuser,
   input wire logic                                           csr_we,
   input wire nrm_pkg::reg_index_type                         csr_index
);

   // A held response keeps its payload and flags while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Reset empties the index pipe.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A new channel count or block width must drop req_tready at the start of the C1 rebuild.
   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == nrm_pkg::REG_CHANNEL || csr_index == nrm_pkg::REG_BLOCK)
         |=> !req_tready ##1 !req_tready)
      else $error("request taken while block count is stale");

   // The first request after reset needs all five stages before it shows up.
   a_min_latency: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid [*5])
      else $error("response appeared too early");

endmodule

bind ndhwc_to_ndc1hwc0_remap nrm_chk #(
   .ELEMENT_BITS (ELEMENT_BITS)
) u_nrm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we),
   .csr_index  (csr_index)
);

`default_nettype wire
